// ----- hw/rtl/dswo_pkg.sv -----
// Shared widths, register indexes, unit control types and the quarter-wave sine generator.
`timescale 1ns / 1ps
`default_nettype none
package dswo_pkg;

   localparam int ELAPSED_W  = 24;
   localparam int INDEX_W    = 16;
   localparam int Y_W        = 24;
   localparam int LENGTH_W   = 12;
   localparam int SPEED_W    = 16;
   localparam int RATE_W     = 24;
   localparam int HEIGHT_W   = 24;
   localparam int PHASE_W    = 16;
   localparam int FRAC_W     = 16;
   localparam int SINE_W     = 15;
   localparam int PROD_W     = 48;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic ACT_TICK  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_WAVE_LENGTH  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_WAVE_SPEED   = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_DECAY_RATE   = CSR_ADDR_W'(2);
   localparam logic [CSR_ADDR_W-1:0] CSR_START_HEIGHT = CSR_ADDR_W'(3);

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   function automatic logic [63:0] sq_step(input logic [63:0] t, input logic [63:0] x);
      logic [63:0] u;
      u = (t * x) >> 30;
      u = (u * x) >> 30;
      return u;
   endfunction

   // Taylor series through x^15 in Q2.30, rounded to Q0.15 and clamped
   function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned bits);
      logic [63:0]        x;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        r;
      x    = (HALF_PI_Q30 * 64'(k)) >> bits;
      term = x;
      sum  = signed'(x);
      term = sq_step(term, x) / 64'd6;
      sum  = sum - signed'(term);
      term = sq_step(term, x) / 64'd20;
      sum  = sum + signed'(term);
      term = sq_step(term, x) / 64'd42;
      sum  = sum - signed'(term);
      term = sq_step(term, x) / 64'd72;
      sum  = sum + signed'(term);
      term = sq_step(term, x) / 64'd110;
      sum  = sum - signed'(term);
      term = sq_step(term, x) / 64'd156;
      sum  = sum + signed'(term);
      term = sq_step(term, x) / 64'd210;
      sum  = sum - signed'(term);
      if (sum < 0) begin
         return '0;
      end
      r = (unsigned'(sum) + 64'd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[SINE_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dswo_if.sv -----
// Request and response channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
interface dswo_req_if import dswo_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [ELAPSED_W-1:0] elapsed;
   logic [INDEX_W-1:0]   element_index;

   modport source (output valid, output action, output elapsed, output element_index,
                   input ready);
   modport sink   (input valid, input action, input elapsed, input element_index,
                   output ready);
endinterface

interface dswo_rsp_if import dswo_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic signed [Y_W-1:0] y_offset;

   modport source (output valid, output y_offset, input ready);
   modport sink   (input valid, input y_offset, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/decaying_sine_wave_offset.sv -----
// Top level of the decaying sine wave offset block.
// Usage:
//   req_bus carries one word per item: action 0 is a time tick (elapsed), action 1
//   an offset query (element_index). Ticks give no response word; each query gives
//   exactly one y_offset word on rsp_bus.
//   csr_we/csr_addr/csr_wdata write wave_length, wave_speed, decay_rate and
//   start_height; writing start_height also loads the current height.
// Sequencing:
//   A tick steps through S_TICK1 to S_TICK3 on the shared 24x24 multiplier.
//   A query runs 16 plus min(INDEX_BITS, 16) divider steps (one quotient bit a
//   cycle) in S_DIV, then S_LOOK reads the table, S_MUL multiplies and S_FIN
//   loads the output word; with zero wave_length a query goes straight to S_FIN.
//   A new item is taken only once the current one is done: req_bus.ready is
//   high only while the sequencer is idle.
// Reset:
//   Synchronous, active high; clears registers, phase and height to zero.
// Stall:
//   The response register holds a finished word while rsp_bus.ready is low; the
//   block still takes the next item and waits at its output step until free.
`timescale 1ns / 1ps
`default_nettype none
module decaying_sine_wave_offset import dswo_pkg::*; #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int INDEX_BITS      = 16,
   parameter int LENGTH_BITS     = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   dswo_req_if.sink                   req_bus,
   dswo_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int B        = SINE_TABLE_BITS;
   localparam int QUARTER  = 1 << B;
   localparam int IDX_KEEP = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
   localparam int LEN_KEEP = (LENGTH_BITS < LENGTH_W) ? LENGTH_BITS : LENGTH_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TICK1 = 3'd1;
   localparam logic [2:0] S_TICK2 = 3'd2;
   localparam logic [2:0] S_TICK3 = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_LOOK  = 3'd5;
   localparam logic [2:0] S_MUL   = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [SPEED_W-1:0]     speed_ff, speed_in;
   logic [RATE_W-1:0]      decay_ff, decay_in;
   logic [HEIGHT_W-1:0]    height_ff, height_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [ELAPSED_W-1:0]   elapsed_ff, elapsed_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [SINE_W-1:0]      sine_ff, sine_in;
   logic                   neg_ff, neg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [Y_W-1:0]         y_ff, y_in;

   logic [23:0]            mul_a, mul_b;
   logic                   accept;
   logic                   slot_free;
   logic [PHASE_W-1:0]     angle;
   logic [B-1:0]           tab_idx;
   logic [B:0]             rom_addr;
   logic [31:0]            dec;
   logic [Y_W-1:0]         mag;
   logic [SINE_W-1:0]      sine_rom [0:QUARTER];
   div_ctl_type            div_ctl;
   div_sts_type            div_sts;
   logic [FRAC_W-1:0]      frac;

   for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
      assign sine_rom[k] = quarter_sine(k, B);
   end

   dswo_div #(
      .IDX_W (IDX_KEEP),
      .LEN_W (LENGTH_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (req_bus.element_index[IDX_KEEP-1:0]),
      .divisor  (len_ff),
      .sts      (div_sts),
      .frac     (frac)
   );

   assign accept         = req_bus.valid && req_bus.ready;
   assign slot_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready  = (state_ff == S_IDLE);
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.y_offset = y_ff;

   always_comb begin
      case (state_ff)
         S_TICK1: begin
            mul_a = elapsed_ff;
            mul_b = 24'(speed_ff);
         end
         S_TICK2: begin
            mul_a = elapsed_ff;
            mul_b = decay_ff;
         end
         S_MUL: begin
            mul_a = height_ff;
            mul_b = 24'(sine_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      angle    = phase_ff + frac;
      tab_idx  = angle[13 -: B];
      rom_addr = angle[14] ? ((B+1)'(QUARTER) - {1'b0, tab_idx}) : {1'b0, tab_idx};
      dec      = prod_ff[47:16];
      mag      = {1'b0, prod_ff[16 +: Y_W-1]};

      state_in     = state_ff;
      len_in       = len_ff;
      speed_in     = speed_ff;
      decay_in     = decay_ff;
      height_in    = height_ff;
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      prod_in      = (state_ff == S_FIN) ? prod_ff : PROD_W'(mul_a) * PROD_W'(mul_b);
      sine_in      = sine_ff;
      neg_in       = neg_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      div_ctl.start = 1'b0;

      if (csr_we) begin
         case (csr_addr)
            CSR_WAVE_LENGTH:  len_in    = LENGTH_BITS'(csr_wdata[LEN_KEEP-1:0]);
            CSR_WAVE_SPEED:   speed_in  = csr_wdata[SPEED_W-1:0];
            CSR_DECAY_RATE:   decay_in  = csr_wdata[RATE_W-1:0];
            CSR_START_HEIGHT: height_in = csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               elapsed_in = req_bus.elapsed;
               neg_in     = 1'b0;
               if (req_bus.action == ACT_TICK) begin
                  state_in = S_TICK1;
               end else if (len_ff == '0) begin
                  state_in = S_FIN;
               end else begin
                  div_ctl.start = 1'b1;
                  state_in      = S_DIV;
               end
            end
         end
         S_TICK1: state_in = S_TICK2;
         S_TICK2: begin
            phase_in = phase_ff + prod_ff[23:8];
            state_in = S_TICK3;
         end
         S_TICK3: begin
            height_in = (32'(height_ff) <= dec) ? '0 : height_ff - dec[HEIGHT_W-1:0];
            state_in  = S_IDLE;
         end
         S_DIV: begin
            if (div_sts.done) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            sine_in  = sine_rom[rom_addr];
            neg_in   = angle[15];
            state_in = S_MUL;
         end
         S_MUL: state_in = S_FIN;
         S_FIN: begin
            if (slot_free) begin
               y_in         = neg_ff ? (Y_W'(0) - mag) : mag;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
         speed_ff     <= '0;
         decay_ff     <= '0;
         height_ff    <= '0;
         phase_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         speed_ff     <= speed_in;
         decay_ff     <= decay_in;
         height_ff    <= height_in;
         phase_ff     <= phase_in;
      end
      elapsed_ff <= elapsed_in;
      prod_ff    <= prod_in;
      sine_ff    <= sine_in;
      neg_ff     <= neg_in;
      y_ff       <= y_in;
   end

`ifndef SYNTHESIS
   a_div_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_sts.busy || div_sts.done))
      else $error("divider idle while sequencer waits on it");

   a_height_decays: assert property (@(posedge clock) disable iff (reset)
      !csr_we |=> (height_ff <= $past(height_ff)))
      else $error("height grew without a register write");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN))
      else $error("response word loaded outside the output step");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/dswo_div.sv -----
// Shift-compare-subtract unit: index mod length, then the fraction of the period.
`timescale 1ns / 1ps
`default_nettype none
module dswo_div import dswo_pkg::*; #(
   parameter int IDX_W = 16,
   parameter int LEN_W = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire div_ctl_type       ctl,
   input  wire logic [IDX_W-1:0]  dividend,
   input  wire logic [LEN_W-1:0]  divisor,
   output div_sts_type            sts,
   output logic [FRAC_W-1:0]      frac
);

   localparam int STEPS = IDX_W + FRAC_W;
   localparam int CNT_W = $clog2(STEPS);

   logic [STEPS-1:0]  shift_ff, shift_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [FRAC_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [LEN_W:0]    trial;
   logic              fits;

   always_comb begin
      trial    = {rem_ff, shift_ff[STEPS-1]};
      fits     = (trial >= {1'b0, divisor});
      shift_in = shift_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctl.start) begin
         shift_in = {dividend, FRAC_W'(0)};
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         rem_in   = fits ? LEN_W'(trial - {1'b0, divisor}) : trial[LEN_W-1:0];
         quo_in   = {quo_ff[FRAC_W-2:0], fits};
         cnt_in   = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign frac     = quo_ff;

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for the decaying sine wave offset: directed and random ticks and queries.
`timescale 1ns / 1ps
module tb;
   import dswo_pkg::*;

   localparam int TABLE_BITS  = 10;
   localparam int QUARTER     = 1 << TABLE_BITS;
   localparam int SETTLE      = 48;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 124;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dswo_req_if req_bus ();
   dswo_rsp_if rsp_bus ();

   decaying_sine_wave_offset uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   logic [SINE_W-1:0]   sine_quarter [0:QUARTER];
   logic [LENGTH_W-1:0] cfg_length;
   logic [SPEED_W-1:0]  cfg_speed;
   logic [RATE_W-1:0]   cfg_rate;
   logic [PHASE_W-1:0]  wave_phase;
   logic [HEIGHT_W-1:0] wave_height;
   logic [Y_W-1:0]      pending_offsets [$];
   logic [Y_W-1:0]      expected_word;
   bit                  idling;
   int                  failures;
   int                  ticks_sent;
   int                  queries_sent;
   int                  words_checked;
   int                  rsp_hold;
   int                  quiet_cycles;

   always #10 clock = ~clock;

   function automatic logic [SINE_W-1:0] sine_sample(input int unsigned k);
      logic [63:0] x;
      logic [63:0] t;
      logic [63:0] rounded;
      longint      acc;
      int          n;
      x   = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
      t   = x;
      acc = longint'(x);
      for (n = 1; n <= 7; n++) begin
         t = (t * x) >> 30;
         t = (t * x) >> 30;
         t = t / 64'(2 * n * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(t);
         end else begin
            acc = acc + longint'(t);
         end
      end
      if (acc < 0) begin
         return '0;
      end
      rounded = (64'(acc) + 64'd16384) >> 15;
      if (rounded > 64'd32767) begin
         rounded = 64'd32767;
      end
      return rounded[SINE_W-1:0];
   endfunction

   function automatic void advance_time(input logic [ELAPSED_W-1:0] elapsed);
      logic [39:0] turn;
      logic [47:0] drop;
      turn       = 40'(elapsed) * 40'(cfg_speed);
      drop       = (48'(elapsed) * 48'(cfg_rate)) >> 16;
      wave_phase = wave_phase + turn[23:8];
      if (48'(wave_height) <= drop) begin
         wave_height = '0;
      end else begin
         wave_height = wave_height - drop[HEIGHT_W-1:0];
      end
   endfunction

   function automatic logic [Y_W-1:0] offset_for(input logic [INDEX_W-1:0] index);
      logic [LENGTH_W-1:0] r;
      logic [31:0]         frac;
      logic [PHASE_W-1:0]  angle;
      int unsigned         slot;
      logic [SINE_W-1:0]   s;
      logic [39:0]         mag;
      if (cfg_length == '0) begin
         return '0;
      end
      r     = LENGTH_W'(index % cfg_length);
      frac  = (32'(r) << 16) / 32'(cfg_length);
      angle = wave_phase + frac[PHASE_W-1:0];
      slot  = 32'(angle[13:0]) >> (14 - TABLE_BITS);
      s     = angle[14] ? sine_quarter[QUARTER - slot] : sine_quarter[slot];
      mag   = (40'(wave_height) * 40'(s)) >> 16;
      if (angle[15]) begin
         mag = -mag;
      end
      return mag[Y_W-1:0];
   endfunction

   task automatic put_register(input logic [CSR_ADDR_W-1:0] addr,
                               input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      case (addr)
         CSR_WAVE_LENGTH: cfg_length = data[LENGTH_W-1:0];
         CSR_WAVE_SPEED:  cfg_speed  = data[SPEED_W-1:0];
         CSR_DECAY_RATE:  cfg_rate   = data[RATE_W-1:0];
         CSR_START_HEIGHT: begin
            wave_height = data[HEIGHT_W-1:0];
         end
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [LENGTH_W-1:0] length,
                                input logic [SPEED_W-1:0]  speed,
                                input logic [RATE_W-1:0]   rate,
                                input logic [HEIGHT_W-1:0] start);
      put_register(CSR_WAVE_LENGTH, CSR_DATA_W'(length));
      put_register(CSR_WAVE_SPEED, CSR_DATA_W'(speed));
      put_register(CSR_DECAY_RATE, CSR_DATA_W'(rate));
      put_register(CSR_START_HEIGHT, CSR_DATA_W'(start));
      csr_we <= 1'b0;
   endtask

   task automatic send_word(input logic                 action,
                            input logic [ELAPSED_W-1:0] elapsed,
                            input logic [INDEX_W-1:0]   index);
      int gap;
      gap = idling ? int'($urandom_range(0, 7)) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.action        <= action;
      req_bus.elapsed       <= elapsed;
      req_bus.element_index <= index;
      do @(posedge clock); while (!req_bus.ready);
      if (action == ACT_TICK) begin
         advance_time(elapsed);
         ticks_sent++;
      end else begin
         pending_offsets = {pending_offsets, offset_for(index)};
         queries_sent++;
      end
   endtask

   task automatic tick(input logic [ELAPSED_W-1:0] elapsed);
      send_word(ACT_TICK, elapsed, INDEX_W'($urandom));
   endtask

   task automatic query(input logic [INDEX_W-1:0] index);
      send_word(ACT_QUERY, ELAPSED_W'($urandom), index);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_offsets.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // zero length straight out of reset
   task automatic test_reset_defaults();
      idling = 1'b0;
      query(16'hFFFF);
      tick(24'hFFFFFF);
      query(16'h0000);
      drain();
   endtask

   // one full period over eight elements, then the widest phase step
   task automatic test_wave_shape();
      int i;
      idling = 1'b1;
      load_settings(12'd8, 16'hFFFF, 24'h000000, 24'hFFFFFF);
      for (i = 0; i < 8; i++) begin
         query(INDEX_W'(i));
      end
      query(16'hFFFF);
      tick(24'hFFFFFF);
      query(16'd3);
      drain();
   endtask

   // decrement equal to the height clears it
   task automatic test_decay_to_zero();
      idling = 1'b1;
      load_settings(12'd4095, 16'h0100, 24'h000100, 24'h000200);
      tick(24'h010000);
      query(16'd1000);
      tick(24'h010000);
      query(16'd1000);
      query(16'd4094);
      drain();
   endtask

   // one-element period, full rate
   task automatic test_single_element();
      idling = 1'b0;
      load_settings(12'd1, 16'h0000, 24'hFFFFFF, 24'hFFFFFF);
      query(16'd12345);
      tick(24'h000000);
      query(16'd0);
      tick(24'hFFFFFF);
      query(16'hFFFF);
      drain();
   endtask

   task automatic test_random_settings();
      int                  p;
      int                  i;
      logic [LENGTH_W-1:0] length;
      logic [SPEED_W-1:0]  speed;
      logic [RATE_W-1:0]   rate;
      logic [HEIGHT_W-1:0] start;
      for (p = 0; p < PHASES; p++) begin
         idling = (p % 3 != 2);
         case ($urandom_range(0, 5))
            0:       length = '0;
            1:       length = 12'd1;
            2:       length = 12'd4095;
            3:       length = LENGTH_W'($urandom_range(2, 16));
            default: length = LENGTH_W'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0:       speed = '0;
            1:       speed = 16'hFFFF;
            2:       speed = SPEED_W'($urandom_range(0, 16'h03FF));
            default: speed = SPEED_W'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0:       rate = '0;
            1:       rate = 24'hFFFFFF;
            2:       rate = RATE_W'($urandom_range(0, 24'h003FFF));
            default: rate = RATE_W'($urandom);
         endcase
         case ($urandom_range(0, 2))
            0:       start = 24'hFFFFFF;
            1:       start = HEIGHT_W'($urandom_range(0, 24'h0000FF));
            default: start = HEIGHT_W'($urandom);
         endcase
         load_settings(length, speed, rate, start);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(0, 9) < 6) begin
               query(INDEX_W'($urandom));
            end else if ($urandom_range(0, 3) == 0) begin
               tick(ELAPSED_W'($urandom));
            end else begin
               tick(ELAPSED_W'($urandom_range(0, 24'h0003FF)));
            end
         end
         drain();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_offsets.size() == 0) begin
               $error("y_offset: word with no query outstanding, actual %0d", rsp_bus.y_offset);
               failures++;
            end else begin
               expected_word = pending_offsets.pop_front();
               if (rsp_bus.y_offset !== expected_word) begin
                  $error("y_offset mismatch: expected %0d, actual %0d",
                         $signed(expected_word), rsp_bus.y_offset);
                  failures++;
               end
               words_checked++;
            end
            rsp_hold = idling ? int'($urandom_range(0, 7)) : 0;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_bus.ready <= (rsp_hold == 0);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int k;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_addr              = CSR_WAVE_LENGTH;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.action        = ACT_TICK;
      req_bus.elapsed       = '0;
      req_bus.element_index = '0;
      rsp_bus.ready         = 1'b0;
      cfg_length            = '0;
      cfg_speed             = '0;
      cfg_rate              = '0;
      wave_phase            = '0;
      wave_height           = '0;
      idling                = 1'b0;
      for (k = 0; k <= QUARTER; k++) begin
         sine_quarter[k] = sine_sample(k);
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_wave_shape();
      test_decay_to_zero();
      test_single_element();
      test_random_settings();
      drain();
      $display("Run covered %0d ticks and %0d queries over %0d register settings.",
               ticks_sent, queries_sent, PHASES + 4);
      $display("%0d offset words compared, %0d mismatches.", words_checked, failures);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
